// ===== sv/fmsp_pkg.sv =====
// Shared types and constants for the file mode string parser.
package fmsp_pkg;

	typedef logic [7:0]  char_t;
	typedef logic [11:0] mode_t;
	typedef logic [2:0]  status_t;
	typedef logic [1:0]  kind_t;
	typedef logic [1:0]  phase_t;

	localparam mode_t ALL_BITS   = 12'o7777;
	localparam mode_t WHO_USER   = 12'o4700;
	localparam mode_t WHO_GROUP  = 12'o2070;
	localparam mode_t WHO_OTHER  = 12'o0007;
	localparam mode_t PERM_READ  = 12'o0444;
	localparam mode_t PERM_WRITE = 12'o0222;
	localparam mode_t PERM_EXEC  = 12'o0111;
	localparam mode_t PERM_SUID  = 12'o6000;
	localparam mode_t PERM_STICK = 12'o1000;

	localparam kind_t KIND_EQUALS = 2'd0;
	localparam kind_t KIND_PLUS   = 2'd1;
	localparam kind_t KIND_MINUS  = 2'd2;

	localparam phase_t PHASE_UNKNOWN = 2'd0;
	localparam phase_t PHASE_WHO     = 2'd1;
	localparam phase_t PHASE_WHICH   = 2'd2;

	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_EXTRA_OP   = 3'd1;
	localparam status_t ST_TOO_BIG    = 3'd2;
	localparam status_t ST_INCOMPLETE = 3'd3;
	localparam status_t ST_INVALID    = 3'd4;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_A     = 8'h61;
	localparam char_t CH_U     = 8'h75;
	localparam char_t CH_G     = 8'h67;
	localparam char_t CH_O     = 8'h6f;
	localparam char_t CH_PLUS  = 8'h2b;
	localparam char_t CH_MINUS = 8'h2d;
	localparam char_t CH_EQ    = 8'h3d;
	localparam char_t CH_R     = 8'h72;
	localparam char_t CH_W     = 8'h77;
	localparam char_t CH_X     = 8'h78;
	localparam char_t CH_S     = 8'h73;
	localparam char_t CH_T     = 8'h74;
	localparam char_t CH_COMMA = 8'h2c;
	localparam char_t CH_0     = 8'h30;
	localparam char_t CH_7     = 8'h37;
	localparam char_t CH_8     = 8'h38;
	localparam char_t CH_9     = 8'h39;

	localparam logic [2:0] ZERO_SAT = 3'd7;

endpackage

// ===== sv/fmsp_channel_if.sv =====
// Valid/ready channel interfaces for characters in and parse results out.
interface fmsp_char_if;
	logic                 valid;
	logic                 ready;
	fmsp_pkg::char_t      char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface fmsp_result_if;
	logic                 valid;
	logic                 ready;
	fmsp_pkg::status_t    status;
	fmsp_pkg::mode_t      plus_mask;
	fmsp_pkg::mode_t      minus_mask;

	modport source (output valid, output status, output plus_mask, output minus_mask,
		input ready);
	modport sink   (input valid, input status, input plus_mask, input minus_mask,
		output ready);
endinterface

// ===== sv/file_mode_string_parser.sv =====
// Streaming chmod-style mode string parser, one character per cycle while no NUL waits.
// A NUL character's result is valid once the NUL moves from the input register into the result register.
// Throughput: one character per cycle while no NUL waits; the parse state updates
// from the registered character, so characters may arrive back to back.
// A NUL waits in the input register only while the result register holds a result not taken.
// Reset (arst_n low): all parse state returns to its initial values, no result.
module file_mode_string_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	fmsp_char_if.sink            char_in,
	fmsp_result_if.source        res_out
);

	// input register
	logic                  vld_s1;
	fmsp_pkg::char_t       char_s1;

	// parse state
	fmsp_pkg::mode_t       who_q, perm_q, plus_q, minus_q;
	fmsp_pkg::kind_t       kind_q;
	fmsp_pkg::phase_t      phase_q;
	logic                  op_seen_q, run_q, stopped_q, only_zeros_q;
	fmsp_pkg::status_t     err_q;
	logic [2:0]            zcnt_q;

	// result register
	logic                  out_vld_q;
	fmsp_pkg::status_t     out_status_q;
	fmsp_pkg::mode_t       out_plus_q, out_minus_q;

	// next values
	fmsp_pkg::mode_t       who_d, perm_d, plus_d, minus_d;
	fmsp_pkg::kind_t       kind_d;
	fmsp_pkg::phase_t      phase_d;
	logic                  op_seen_d, run_d, stopped_d, only_zeros_d;
	fmsp_pkg::status_t     err_d;
	logic [2:0]            zcnt_d;
	fmsp_pkg::status_t     res_status;
	fmsp_pkg::mode_t       res_plus, res_minus;

	fmsp_pkg::mode_t       fold_plus, fold_minus;
	logic [14:0]           acc_next;
	logic                  is_nul, is_dec, out_free, adv_s1, exact, skip;

	assign is_nul   = (char_s1 == fmsp_pkg::CH_NUL);
	assign is_dec   = (char_s1 >= fmsp_pkg::CH_0) && (char_s1 <= fmsp_pkg::CH_9);
	assign out_free = !out_vld_q || res_out.ready;
	assign adv_s1   = vld_s1 && (!is_nul || out_free);

	assign char_in.ready = !vld_s1 || adv_s1;

	assign res_out.valid      = out_vld_q;
	assign res_out.status     = out_status_q;
	assign res_out.plus_mask  = out_plus_q;
	assign res_out.minus_mask = out_minus_q;

	// clause fold into the accumulated masks
	always_comb begin
		fold_plus  = plus_q;
		fold_minus = minus_q;
		case (kind_q)
			fmsp_pkg::KIND_PLUS:  fold_plus  = plus_q | perm_q;
			fmsp_pkg::KIND_MINUS: fold_minus = minus_q | perm_q;
			default: begin
				fold_plus  = plus_q | perm_q;
				fold_minus = minus_q | (~perm_q & who_q);
			end
		endcase
	end

	assign acc_next = {perm_q, 3'b000} + {12'd0, char_s1[2:0]};
	assign exact    = only_zeros_q && (zcnt_q == 3'd3 || zcnt_q == 3'd4);

	always_comb begin
		who_d        = who_q;
		perm_d       = perm_q;
		plus_d       = plus_q;
		minus_d      = minus_q;
		kind_d       = kind_q;
		phase_d      = phase_q;
		op_seen_d    = op_seen_q;
		run_d        = run_q;
		stopped_d    = stopped_q;
		only_zeros_d = only_zeros_q;
		err_d        = err_q;
		zcnt_d       = zcnt_q;
		res_status   = err_q;
		res_plus     = '0;
		res_minus    = '0;
		skip         = 1'b0;

		if (is_nul) begin
			if (err_q == fmsp_pkg::ST_OK) begin
				if ((phase_q == fmsp_pkg::PHASE_WHO || perm_q == '0) && !exact) begin
					res_status = fmsp_pkg::ST_INCOMPLETE;
				end else begin
					res_plus  = fold_plus;
					res_minus = fold_minus;
				end
			end
			// back to the initial state for the next string
			who_d        = '0;
			perm_d       = '0;
			plus_d       = '0;
			minus_d      = '0;
			kind_d       = fmsp_pkg::KIND_EQUALS;
			phase_d      = fmsp_pkg::PHASE_UNKNOWN;
			op_seen_d    = 1'b0;
			run_d        = 1'b0;
			stopped_d    = 1'b0;
			only_zeros_d = 1'b1;
			err_d        = fmsp_pkg::ST_OK;
			zcnt_d       = '0;
		end else if (err_q == fmsp_pkg::ST_OK) begin
			if (only_zeros_q && char_s1 == fmsp_pkg::CH_0) begin
				if (zcnt_q != fmsp_pkg::ZERO_SAT)
					zcnt_d = zcnt_q + 3'd1;
			end else begin
				only_zeros_d = 1'b0;
			end

			if (run_q) begin
				if (is_dec) begin
					skip = 1'b1;
					if (!stopped_q) begin
						if (char_s1 >= fmsp_pkg::CH_8)
							stopped_d = 1'b1;
						else if (acc_next[14:12] != 3'd0)
							err_d = fmsp_pkg::ST_TOO_BIG;
						else
							perm_d = acc_next[11:0];
					end
				end else begin
					run_d     = 1'b0;
					stopped_d = 1'b0;
				end
			end

			if (!skip) begin
				case (char_s1) inside
					fmsp_pkg::CH_A: who_d = who_q | fmsp_pkg::ALL_BITS;
					fmsp_pkg::CH_U: who_d = who_q | fmsp_pkg::WHO_USER;
					fmsp_pkg::CH_G: who_d = who_q | fmsp_pkg::WHO_GROUP;
					fmsp_pkg::CH_O: who_d = who_q | fmsp_pkg::WHO_OTHER;
					fmsp_pkg::CH_PLUS, fmsp_pkg::CH_MINUS, fmsp_pkg::CH_EQ: begin
						if (op_seen_q) begin
							err_d = fmsp_pkg::ST_EXTRA_OP;
						end else begin
							if (char_s1 == fmsp_pkg::CH_PLUS)
								kind_d = fmsp_pkg::KIND_PLUS;
							else if (char_s1 == fmsp_pkg::CH_MINUS)
								kind_d = fmsp_pkg::KIND_MINUS;
							else
								kind_d = fmsp_pkg::KIND_EQUALS;
							phase_d   = fmsp_pkg::PHASE_WHICH;
							op_seen_d = 1'b1;
						end
					end
					fmsp_pkg::CH_R: perm_d = perm_q | (fmsp_pkg::PERM_READ & who_q);
					fmsp_pkg::CH_W: perm_d = perm_q | (fmsp_pkg::PERM_WRITE & who_q);
					fmsp_pkg::CH_X: perm_d = perm_q | (fmsp_pkg::PERM_EXEC & who_q);
					fmsp_pkg::CH_S: perm_d = perm_q | (fmsp_pkg::PERM_SUID & who_q);
					fmsp_pkg::CH_T: perm_d = perm_q | fmsp_pkg::PERM_STICK;
					[fmsp_pkg::CH_0:fmsp_pkg::CH_7]: begin
						run_d     = 1'b1;
						stopped_d = 1'b0;
						op_seen_d = 1'b1;
						phase_d   = fmsp_pkg::PHASE_WHICH;
						who_d     = fmsp_pkg::ALL_BITS;
						perm_d    = {9'd0, char_s1[2:0]};
					end
					fmsp_pkg::CH_COMMA: begin
						plus_d    = fold_plus;
						minus_d   = fold_minus;
						who_d     = '0;
						perm_d    = '0;
						kind_d    = fmsp_pkg::KIND_EQUALS;
						op_seen_d = 1'b0;
						phase_d   = fmsp_pkg::PHASE_WHO;
					end
					default: err_d = fmsp_pkg::ST_INVALID;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (char_in.ready) begin
			vld_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.ready && char_in.valid)
			char_s1 <= char_in.char_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			who_q        <= '0;
			perm_q       <= '0;
			plus_q       <= '0;
			minus_q      <= '0;
			kind_q       <= fmsp_pkg::KIND_EQUALS;
			phase_q      <= fmsp_pkg::PHASE_UNKNOWN;
			op_seen_q    <= 1'b0;
			run_q        <= 1'b0;
			stopped_q    <= 1'b0;
			only_zeros_q <= 1'b1;
			err_q        <= fmsp_pkg::ST_OK;
			zcnt_q       <= '0;
		end else if (adv_s1) begin
			who_q        <= who_d;
			perm_q       <= perm_d;
			plus_q       <= plus_d;
			minus_q      <= minus_d;
			kind_q       <= kind_d;
			phase_q      <= phase_d;
			op_seen_q    <= op_seen_d;
			run_q        <= run_d;
			stopped_q    <= stopped_d;
			only_zeros_q <= only_zeros_d;
			err_q        <= err_d;
			zcnt_q       <= zcnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= adv_s1 && is_nul;
		end
	end

	// load the result register on a NUL transfer out of the input register
	always_ff @(posedge clk) begin
		if (adv_s1 && is_nul) begin
			out_status_q <= res_status;
			out_plus_q   <= res_plus;
			out_minus_q  <= res_minus;
		end
	end

endmodule

// ===== sv/fmsp_checker.sv =====
// Port-level checker for the file mode string parser, bound to the parser module.
module fmsp_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  fmsp_pkg::status_t    status,
	input  fmsp_pkg::mode_t      plus_mask,
	input  fmsp_pkg::mode_t      minus_mask
);

	// a rejected string reports empty masks
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != fmsp_pkg::ST_OK |-> plus_mask == '0 && minus_mask == '0)
		else $error("rejected result carries nonzero masks");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status <= fmsp_pkg::ST_INVALID)
		else $error("status code out of range");

	// hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(plus_mask)
			&& $stable(minus_mask))
		else $error("stalled result changed");

endmodule

bind file_mode_string_parser fmsp_checker u_fmsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_out.valid),
	.res_ready  (res_out.ready),
	.status     (res_out.status),
	.plus_mask  (res_out.plus_mask),
	.minus_mask (res_out.minus_mask)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the streaming chmod-style mode string parser.
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		fmsp_pkg::status_t status;
		fmsp_pkg::mode_t   plus_mask;
		fmsp_pkg::mode_t   minus_mask;
	} mode_result_t;

	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;

	fmsp_char_if   char_ch ();
	fmsp_result_if res_ch ();

	file_mode_string_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (char_ch),
		.res_out (res_ch)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Parser state mirrored by the predictor
	fmsp_pkg::mode_t   who_mask;
	fmsp_pkg::mode_t   clause_perm;
	fmsp_pkg::mode_t   plus_acc;
	fmsp_pkg::mode_t   minus_acc;
	fmsp_pkg::kind_t   clause_kind;
	fmsp_pkg::phase_t  clause_stage;
	logic              op_taken;
	logic              digits_open;
	logic              digits_halted;
	logic              only_zero_chars;
	logic [2:0]        zero_run;
	fmsp_pkg::status_t first_fault;

	mode_result_t expected_modes[$];

	int          sender_idle_pct = 0;
	int          sink_stall_pct  = 0;
	int          hold_off_left   = 0;
	int          fault_count     = 0;
	int          useful_chars    = 0;
	int unsigned cycle_count     = 0;

	fmsp_pkg::char_t symbol_set [18] = '{fmsp_pkg::CH_A, fmsp_pkg::CH_U, fmsp_pkg::CH_G,
		fmsp_pkg::CH_O, fmsp_pkg::CH_PLUS, fmsp_pkg::CH_MINUS, fmsp_pkg::CH_EQ,
		fmsp_pkg::CH_R, fmsp_pkg::CH_W, fmsp_pkg::CH_X, fmsp_pkg::CH_S, fmsp_pkg::CH_T,
		fmsp_pkg::CH_COMMA, fmsp_pkg::CH_0, fmsp_pkg::CH_7, fmsp_pkg::CH_8, fmsp_pkg::CH_9,
		8'h35};
	fmsp_pkg::char_t who_set [4]  = '{fmsp_pkg::CH_A, fmsp_pkg::CH_U, fmsp_pkg::CH_G,
		fmsp_pkg::CH_O};
	fmsp_pkg::char_t op_set [3]   = '{fmsp_pkg::CH_PLUS, fmsp_pkg::CH_MINUS, fmsp_pkg::CH_EQ};
	fmsp_pkg::char_t perm_set [5] = '{fmsp_pkg::CH_R, fmsp_pkg::CH_W, fmsp_pkg::CH_X,
		fmsp_pkg::CH_S, fmsp_pkg::CH_T};

	function automatic void clear_parse();
		who_mask        = '0;
		clause_perm     = '0;
		plus_acc        = '0;
		minus_acc       = '0;
		clause_kind     = fmsp_pkg::KIND_EQUALS;
		clause_stage    = fmsp_pkg::PHASE_UNKNOWN;
		op_taken        = 1'b0;
		digits_open     = 1'b0;
		digits_halted   = 1'b0;
		only_zero_chars = 1'b1;
		zero_run        = '0;
		first_fault     = fmsp_pkg::ST_OK;
	endfunction

	function automatic void merge_clause();
		case (clause_kind)
			fmsp_pkg::KIND_PLUS: plus_acc |= clause_perm;
			fmsp_pkg::KIND_MINUS: minus_acc |= clause_perm;
			default: begin
				plus_acc  |= clause_perm;
				minus_acc |= ~clause_perm & who_mask;
			end
		endcase
	endfunction

	task automatic predict_char(input fmsp_pkg::char_t c);
		mode_result_t res;
		logic [14:0]  grown;
		logic         consumed;
		consumed = 1'b0;
		if (c == fmsp_pkg::CH_NUL) begin
			res.status     = first_fault;
			res.plus_mask  = '0;
			res.minus_mask = '0;
			if (first_fault == fmsp_pkg::ST_OK) begin
				if ((clause_stage == fmsp_pkg::PHASE_WHO || clause_perm == '0) &&
					!(only_zero_chars && (zero_run == 3'd3 || zero_run == 3'd4))) begin
					res.status = fmsp_pkg::ST_INCOMPLETE;
				end else begin
					merge_clause();
					res.plus_mask  = plus_acc;
					res.minus_mask = minus_acc;
				end
			end
			expected_modes.push_back(res);
			clear_parse();
		end else if (first_fault == fmsp_pkg::ST_OK) begin
			if (only_zero_chars && c == fmsp_pkg::CH_0) begin
				if (zero_run != fmsp_pkg::ZERO_SAT)
					zero_run++;
			end else begin
				only_zero_chars = 1'b0;
			end
			if (digits_open) begin
				if (c >= fmsp_pkg::CH_0 && c <= fmsp_pkg::CH_9) begin
					consumed = 1'b1;
					// after an 8 or 9 the rest of the digit run is dropped
					if (!digits_halted) begin
						if (c >= fmsp_pkg::CH_8) begin
							digits_halted = 1'b1;
						end else begin
							grown = {clause_perm, 3'b000} | 15'(c[2:0]);
							if (grown > 15'(fmsp_pkg::ALL_BITS))
								first_fault = fmsp_pkg::ST_TOO_BIG;
							else
								clause_perm = grown[11:0];
						end
					end
				end else begin
					digits_open   = 1'b0;
					digits_halted = 1'b0;
				end
			end
			if (!consumed) begin
				case (c)
					fmsp_pkg::CH_A: who_mask |= fmsp_pkg::ALL_BITS;
					fmsp_pkg::CH_U: who_mask |= fmsp_pkg::WHO_USER;
					fmsp_pkg::CH_G: who_mask |= fmsp_pkg::WHO_GROUP;
					fmsp_pkg::CH_O: who_mask |= fmsp_pkg::WHO_OTHER;
					fmsp_pkg::CH_PLUS, fmsp_pkg::CH_MINUS, fmsp_pkg::CH_EQ: begin
						if (op_taken) begin
							first_fault = fmsp_pkg::ST_EXTRA_OP;
						end else begin
							clause_kind  = (c == fmsp_pkg::CH_PLUS) ? fmsp_pkg::KIND_PLUS :
								(c == fmsp_pkg::CH_MINUS) ? fmsp_pkg::KIND_MINUS :
								fmsp_pkg::KIND_EQUALS;
							clause_stage = fmsp_pkg::PHASE_WHICH;
							op_taken     = 1'b1;
						end
					end
					fmsp_pkg::CH_R: clause_perm |= fmsp_pkg::PERM_READ & who_mask;
					fmsp_pkg::CH_W: clause_perm |= fmsp_pkg::PERM_WRITE & who_mask;
					fmsp_pkg::CH_X: clause_perm |= fmsp_pkg::PERM_EXEC & who_mask;
					fmsp_pkg::CH_S: clause_perm |= fmsp_pkg::PERM_SUID & who_mask;
					fmsp_pkg::CH_T: clause_perm |= fmsp_pkg::PERM_STICK;
					fmsp_pkg::CH_COMMA: begin
						merge_clause();
						who_mask     = '0;
						clause_perm  = '0;
						clause_kind  = fmsp_pkg::KIND_EQUALS;
						op_taken     = 1'b0;
						clause_stage = fmsp_pkg::PHASE_WHO;
					end
					default: begin
						if (c >= fmsp_pkg::CH_0 && c <= fmsp_pkg::CH_7) begin
							digits_open   = 1'b1;
							digits_halted = 1'b0;
							op_taken      = 1'b1;
							clause_stage  = fmsp_pkg::PHASE_WHICH;
							who_mask      = fmsp_pkg::ALL_BITS;
							clause_perm   = {9'd0, c[2:0]};
						end else begin
							first_fault = fmsp_pkg::ST_INVALID;
						end
					end
				endcase
			end
		end
	endtask

	// Called at a falling edge; returns at a falling edge
	task automatic send_char(input fmsp_pkg::char_t c);
		while ($urandom_range(99) < sender_idle_pct)
			@(negedge clk);
		char_ch.char_code = c;
		char_ch.valid     = 1'b1;
		@(posedge clk);
		while (!char_ch.ready)
			@(posedge clk);
		if (first_fault == fmsp_pkg::ST_OK)
			useful_chars++;
		predict_char(c);
		@(negedge clk);
		char_ch.valid = 1'b0;
	endtask

	task automatic send_mode(input string text);
		for (int i = 0; i < text.len(); i++)
			send_char(fmsp_pkg::char_t'(text[i]));
		send_char(fmsp_pkg::CH_NUL);
	endtask

	task automatic wait_drained();
		while (expected_modes.size() != 0)
			@(negedge clk);
	endtask

	function automatic fmsp_pkg::char_t noise_char();
		if ($urandom_range(1) == 0)
			return symbol_set[$urandom_range(17)];
		return fmsp_pkg::char_t'($urandom_range(1, 255));
	endfunction

	task automatic send_symbolic_clause();
		int n;
		n = $urandom_range(3);
		for (int i = 0; i < n; i++)
			send_char(who_set[$urandom_range(3)]);
		if ($urandom_range(99) < 90)
			send_char(op_set[$urandom_range(2)]);
		if ($urandom_range(99) < 5)
			send_char(op_set[$urandom_range(2)]);
		n = $urandom_range(4);
		for (int i = 0; i < n; i++)
			send_char(perm_set[$urandom_range(4)]);
	endtask

	task automatic send_octal_clause();
		int n;
		n = ($urandom_range(99) < 10) ? 5 : $urandom_range(1, 4);
		for (int i = 0; i < n; i++)
			send_char(fmsp_pkg::char_t'(fmsp_pkg::CH_0 + $urandom_range(7)));
		if ($urandom_range(99) < 10) begin
			send_char(($urandom_range(1) == 0) ? fmsp_pkg::CH_8 : fmsp_pkg::CH_9);
			n = $urandom_range(2);
			for (int i = 0; i < n; i++)
				send_char(fmsp_pkg::char_t'(fmsp_pkg::CH_0 + $urandom_range(9)));
		end
	endtask

	task automatic send_random_mode();
		int n;
		if ($urandom_range(99) < 85) begin
			n = $urandom_range(1, 3);
			for (int k = 0; k < n; k++) begin
				if (k > 0)
					send_char(fmsp_pkg::CH_COMMA);
				if ($urandom_range(99) < 60)
					send_symbolic_clause();
				else
					send_octal_clause();
			end
			// a trailing comma leaves the string incomplete
			if ($urandom_range(99) < 5)
				send_char(fmsp_pkg::CH_COMMA);
		end else begin
			n = $urandom_range(1, 8);
			for (int k = 0; k < n; k++)
				send_char(noise_char());
		end
		send_char(fmsp_pkg::CH_NUL);
	endtask

	task automatic test_directed();
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		send_mode("0000");
		send_mode("000");
		send_mode("00");
		send_mode("7777");
		send_mode("10000");
		send_mode("758");
		send_mode("9");
		send_mode("u++");
		send_mode("a=rwxst");
		send_mode("ug-s,o+t");
		send_mode("u=");
		send_mode("u=r,");
		send_mode("");
		send_char(fmsp_pkg::CH_A);
		send_char(8'hff);
		send_char(fmsp_pkg::CH_R);
		send_char(fmsp_pkg::CH_NUL);
		wait_drained();
	endtask

	task automatic test_idle_phases();
		int idle_pct [4]  = '{0, 63, 0, 17};
		int stall_pct [4] = '{0, 0, 63, 17};
		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = idle_pct[p];
			sink_stall_pct  = stall_pct[p];
			useful_chars    = 0;
			while (useful_chars < 220)
				send_random_mode();
			wait_drained();
		end
	endtask

	// Hold the result side off while short strings keep arriving
	task automatic test_full_stall();
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		@(posedge clk);
		hold_off_left = 300;
		@(negedge clk);
		for (int i = 0; i < 30; i++)
			send_mode("7");
		wait_drained();
	endtask

	task automatic test_drain_pause();
		sender_idle_pct = 17;
		sink_stall_pct  = 17;
		for (int i = 0; i < 12; i++) begin
			send_random_mode();
			wait_drained();
		end
	endtask

	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			res_ch.ready = 1'b0;
			hold_off_left--;
		end else begin
			res_ch.ready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		mode_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_modes.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: status %0d plus %o minus %o",
						res_ch.status, res_ch.plus_mask, res_ch.minus_mask);
			end else begin
				want = expected_modes.pop_front();
				if (res_ch.status !== want.status || res_ch.plus_mask !== want.plus_mask ||
					res_ch.minus_mask !== want.minus_mask) begin
					fault_count++;
					if (fault_count <= 10)
						$display({"mismatch: expected status %0d plus %o minus %o, ",
							"got status %0d plus %o minus %o"},
							want.status, want.plus_mask, want.minus_mask,
							res_ch.status, res_ch.plus_mask, res_ch.minus_mask);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		char_ch.valid     = 1'b0;
		char_ch.char_code = fmsp_pkg::CH_NUL;
		clear_parse();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_idle_phases();
		test_full_stall();
		test_drain_pause();
		wait_drained();
		repeat (8) @(posedge clk);
		if (fault_count == 0 && expected_modes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
